// ===== rtl/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types and constants for the tournament branch predictor: counter
// type, controller states and the per-branch result bundle.
// ----------------------------------------------------------------------------
package tbp_pkg;

	typedef logic [1:0] ctr_t;

	localparam ctr_t CTR_MIN = 2'd0;
	localparam ctr_t CTR_MAX = 2'd3;

	localparam logic [3:0] HIST_LEN_RESET = 4'd10;
	localparam int         HIST_LEN_W     = 4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} tbp_state_t;

	typedef struct packed {
		logic predicted_taken;
		logic prediction_correct;
		logic chose_bimodal;
		logic bimodal_taken;
		logic gshare_taken;
	} tbp_result_t;

endpackage

// ===== rtl/tournament_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Bimodal plus gshare predictor with a per-branch chooser. Counters live in
// three synchronous tables that are read, updated and written back.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start / busy       branch_address, branch_taken
//  result    done (strobe)      predicted_taken, prediction_correct,
//                               chose_bimodal, bimodal_taken, gshare_taken
//  config    cfg_we             cfg_data (history length)
//
//  a branch is a table read, then update and write back; busy is
//  high for the update cycle, so a new branch waits for the last one
//  the result shows for one cycle with done, the cycle after the transfer
//  after reset the tables are cleared, one entry per cycle, with busy
//  high until every entry is cleared
//  the receiver cannot stall; results are never held
// ----------------------------------------------------------------------------
module tournament_branch_predictor
	import tbp_pkg::*;
#(
	parameter int INDEX_BITS   = 10,
	parameter int HISTORY_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [31:0]           branch_address,
	input  logic                  branch_taken,
	output logic                  done,
	output logic                  predicted_taken,
	output logic                  prediction_correct,
	output logic                  chose_bimodal,
	output logic                  bimodal_taken,
	output logic                  gshare_taken,
	input  logic                  cfg_we,
	input  logic [HIST_LEN_W-1:0] cfg_data
);

	localparam int HX_W = (INDEX_BITS > HISTORY_BITS) ? INDEX_BITS : HISTORY_BITS;

	tbp_state_t state_q;
	tbp_state_t state_d;

	logic [INDEX_BITS-1:0]   clr_cnt_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic [HIST_LEN_W-1:0]   hist_len_q;

	logic [INDEX_BITS-1:0] bi_s1;
	logic [INDEX_BITS-1:0] gi_s1;
	logic                  taken_s1;

	logic                    accept;
	logic [HISTORY_BITS-1:0] hist_mask;
	logic [HX_W-1:0]         hist_ext;
	logic [INDEX_BITS-1:0]   bi;
	logic [INDEX_BITS-1:0]   gi;

	ctr_t bc_rd, gc_rd, ch_rd;
	ctr_t bc_next, gc_next, ch_next;

	logic                  wr_en;
	logic [INDEX_BITS-1:0] bi_wr_addr;
	logic [INDEX_BITS-1:0] gi_wr_addr;
	ctr_t                  bc_wr, gc_wr, ch_wr;

	tbp_result_t result;

	// index generation
	always_comb begin
		for (int i = 0; i < HISTORY_BITS; i++) begin
			hist_mask[i] = (5'(i) < {1'b0, hist_len_q});
		end
		hist_ext = '0;
		hist_ext[HISTORY_BITS-1:0] = hist_q & hist_mask;
		bi = branch_address[INDEX_BITS-1:0];
		gi = bi ^ hist_ext[INDEX_BITS-1:0];
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (&clr_cnt_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			hist_q     <= '0;
			hist_len_q <= HIST_LEN_RESET;
		end else begin
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == ST_UPDATE) hist_q <= {hist_q[HISTORY_BITS-2:0], taken_s1};
			if (cfg_we) hist_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bi_s1    <= bi;
			gi_s1    <= gi;
			taken_s1 <= branch_taken;
		end
	end

	// write port: clearing pass or write back of the updated counters
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_en      = 1'b1;
			bi_wr_addr = clr_cnt_q;
			gi_wr_addr = clr_cnt_q;
			bc_wr      = CTR_MIN;
			gc_wr      = CTR_MIN;
			ch_wr      = CTR_MIN;
		end else begin
			wr_en      = (state_q == ST_UPDATE);
			bi_wr_addr = bi_s1;
			gi_wr_addr = gi_s1;
			bc_wr      = bc_next;
			gc_wr      = gc_next;
			ch_wr      = ch_next;
		end
	end

	tbp_table #(.INDEX_BITS(INDEX_BITS)) u_bimodal (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (bi),
		.rd_data (bc_rd),
		.wr_en   (wr_en),
		.wr_addr (bi_wr_addr),
		.wr_data (bc_wr)
	);

	tbp_table #(.INDEX_BITS(INDEX_BITS)) u_gshare (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (gi),
		.rd_data (gc_rd),
		.wr_en   (wr_en),
		.wr_addr (gi_wr_addr),
		.wr_data (gc_wr)
	);

	tbp_table #(.INDEX_BITS(INDEX_BITS)) u_chooser (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (bi),
		.rd_data (ch_rd),
		.wr_en   (wr_en),
		.wr_addr (bi_wr_addr),
		.wr_data (ch_wr)
	);

	tbp_update u_update (
		.bimodal_ctr  (bc_rd),
		.gshare_ctr   (gc_rd),
		.chooser_ctr  (ch_rd),
		.taken        (taken_s1),
		.result       (result),
		.bimodal_next (bc_next),
		.gshare_next  (gc_next),
		.chooser_next (ch_next)
	);

	assign predicted_taken    = result.predicted_taken;
	assign prediction_correct = result.prediction_correct;
	assign chose_bimodal      = result.chose_bimodal;
	assign bimodal_taken      = result.bimodal_taken;
	assign gshare_taken       = result.gshare_taken;

	// checks
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("transfer not followed by a result");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!done && busy))
		else $error("activity during table clear");

	a_correct: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (prediction_correct == (predicted_taken == taken_s1)))
		else $error("correct flag inconsistent with prediction");

endmodule

// ===== rtl/tbp_table.sv =====
// ----------------------------------------------------------------------------
// tbp_table
// Single table of 2-bit counters: one synchronous read port whose data is
// registered, and one write port.
// ----------------------------------------------------------------------------
module tbp_table
	import tbp_pkg::*;
#(
	parameter int INDEX_BITS = 10
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [INDEX_BITS-1:0] rd_addr,
	output ctr_t                  rd_data,
	input  logic                  wr_en,
	input  logic [INDEX_BITS-1:0] wr_addr,
	input  ctr_t                  wr_data
);

	localparam int DEPTH = 1 << INDEX_BITS;

	ctr_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/tbp_update.sv =====
// ----------------------------------------------------------------------------
// tbp_update
// Prediction and update logic: turns the three counters read for a branch and
// its resolved direction into the result and the new counter values.
// ----------------------------------------------------------------------------
module tbp_update
	import tbp_pkg::*;
(
	input  ctr_t        bimodal_ctr,
	input  ctr_t        gshare_ctr,
	input  ctr_t        chooser_ctr,
	input  logic        taken,
	output tbp_result_t result,
	output ctr_t        bimodal_next,
	output ctr_t        gshare_next,
	output ctr_t        chooser_next
);

	function automatic ctr_t sat_step(input ctr_t c, input logic up);
		ctr_t r;
		r = c;
		if (up) begin
			if (c != CTR_MAX) r = c + 2'd1;
		end else begin
			if (c != CTR_MIN) r = c - 2'd1;
		end
		return r;
	endfunction

	logic b_pred;
	logic g_pred;
	logic use_b;
	logic b_ok;
	logic g_ok;
	logic pred;

	always_comb begin
		b_pred = bimodal_ctr[1];
		g_pred = gshare_ctr[1];
		use_b  = chooser_ctr[1];
		b_ok   = (b_pred == taken);
		g_ok   = (g_pred == taken);
		pred   = use_b ? b_pred : g_pred;

		chooser_next = chooser_ctr;
		if (use_b) begin
			if (b_ok && !g_ok) begin
				chooser_next = CTR_MAX;
			end else if (!b_ok && g_ok) begin
				chooser_next = chooser_ctr - 2'd1;
			end
		end else begin
			if (g_ok && !b_ok) begin
				chooser_next = CTR_MIN;
			end else if (!g_ok && b_ok) begin
				chooser_next = chooser_ctr + 2'd1;
			end
		end

		bimodal_next = sat_step(bimodal_ctr, taken);
		gshare_next  = sat_step(gshare_ctr, taken);

		result.predicted_taken    = pred;
		result.prediction_correct = (pred == taken);
		result.chose_bimodal      = use_b;
		result.bimodal_taken      = b_pred;
		result.gshare_taken       = g_pred;
	end

endmodule

// ===== test/tournament_branch_predictor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_tb
// Self-checking bench for the tournament branch predictor. It sends resolved
// branches through the start/busy port and keeps its own copy of the bimodal,
// gshare and chooser tables and the global history to predict every result.
// A directed table is sent first, then random branches at the reset history
// length. Random phases follow, each under a newly written history length.
// Most random branches come from a small set of trained addresses with
// biased, alternating or periodic outcomes, and the rest are noise.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_tb;
	import tbp_pkg::*;

	localparam int IDX_BITS    = 10;
	localparam int HIST_BITS   = 10;
	localparam int TABLE_DEPTH = 1 << IDX_BITS;
	localparam int POOL_SIZE   = 8;
	localparam int N_DIRECTED  = 22;
	localparam int N_PHASES    = 8;
	localparam int IDLE_PCT    = 26;

	typedef struct {
		logic [31:0] addr;
		logic        taken;
		logic        has_want;
		tbp_result_t want;
	} branch_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [31:0]           branch_address;
	logic                  branch_taken;
	logic                  done;
	logic                  predicted_taken;
	logic                  prediction_correct;
	logic                  chose_bimodal;
	logic                  bimodal_taken;
	logic                  gshare_taken;
	logic                  cfg_we;
	logic [HIST_LEN_W-1:0] cfg_data;

	ctr_t                  bim_ctr [TABLE_DEPTH];
	ctr_t                  gsh_ctr [TABLE_DEPTH];
	ctr_t                  sel_ctr [TABLE_DEPTH];
	logic [HIST_BITS-1:0]  ghist;
	logic [HIST_LEN_W-1:0] hist_len;

	tbp_result_t           pending_outcomes [$];
	branch_row_t           directed_rows [N_DIRECTED];
	logic [IDX_BITS-1:0]   pool_idx [POOL_SIZE];
	int unsigned           pool_tick [POOL_SIZE];
	logic [HIST_LEN_W-1:0] phase_len [N_PHASES];

	int unsigned           n_sent;
	int unsigned           n_checked;
	int unsigned           n_errors;
	int unsigned           n_mispredicts;
	logic                  idle_enable;

	tournament_branch_predictor dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.branch_address    (branch_address),
		.branch_taken      (branch_taken),
		.done              (done),
		.predicted_taken   (predicted_taken),
		.prediction_correct(prediction_correct),
		.chose_bimodal     (chose_bimodal),
		.bimodal_taken     (bimodal_taken),
		.gshare_taken      (gshare_taken),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[tournament_branch_predictor] ERROR");
		$finish;
	end

	function automatic ctr_t ctr_step(input ctr_t c, input logic up);
		if (up) begin
			return (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + 2'd1);
		end
		return (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - 2'd1);
	endfunction

	function automatic tbp_result_t predict_branch(input logic [31:0] addr,
			input logic taken);
		int unsigned         eff_len;
		logic [31:0]         hmask;
		logic [IDX_BITS-1:0] bi;
		logic [IDX_BITS-1:0] gi;
		ctr_t                bc;
		ctr_t                gc;
		ctr_t                sc;
		logic                b_ok;
		logic                g_ok;
		tbp_result_t         r;
		eff_len = (hist_len > HIST_BITS) ? HIST_BITS : hist_len;
		hmask = (32'd1 << eff_len) - 32'd1;
		bi = addr[IDX_BITS-1:0];
		gi = bi ^ IDX_BITS'(ghist & hmask[HIST_BITS-1:0]);
		bc = bim_ctr[bi];
		gc = gsh_ctr[gi];
		sc = sel_ctr[bi];
		r.bimodal_taken = bc[1];
		r.gshare_taken = gc[1];
		r.chose_bimodal = sc[1];
		r.predicted_taken = sc[1] ? bc[1] : gc[1];
		r.prediction_correct = (r.predicted_taken == taken);
		b_ok = (bc[1] == taken);
		g_ok = (gc[1] == taken);
		if (sc[1]) begin
			if (b_ok && !g_ok) begin
				sc = CTR_MAX;
			end else if (!b_ok && g_ok) begin
				sc = ctr_t'(sc - 2'd1);
			end
		end else begin
			if (g_ok && !b_ok) begin
				sc = CTR_MIN;
			end else if (!g_ok && b_ok) begin
				sc = ctr_t'(sc + 2'd1);
			end
		end
		sel_ctr[bi] = sc;
		bim_ctr[bi] = ctr_step(bc, taken);
		gsh_ctr[gi] = ctr_step(gc, taken);
		ghist = {ghist[HIST_BITS-2:0], taken};
		return r;
	endfunction

	// one transfer, with random idle cycles ahead of it when idling is enabled
	task automatic send_branch(input logic [31:0] addr, input logic taken,
			input logic has_want, input tbp_result_t want);
		tbp_result_t r;
		while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		branch_address <= addr;
		branch_taken <= taken;
		do @(posedge clk); while (busy);
		r = predict_branch(addr, taken);
		pending_outcomes.push_back(has_want ? want : r);
		n_sent++;
	endtask

	task automatic write_history_length(input logic [HIST_LEN_W-1:0] v);
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		hist_len = v;
	endtask

	task automatic run_random_branches(input int count);
		int          k;
		logic [31:0] addr;
		logic        taken;
		for (int p = 0; p < POOL_SIZE; p++) begin
			pool_idx[p] = IDX_BITS'($urandom);
			pool_tick[p] = 0;
		end
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(POOL_SIZE - 1);
			addr = $urandom;
			addr[IDX_BITS-1:0] = pool_idx[k];
			case (k % 4)
				0: taken = ($urandom_range(99) < 90);
				1: taken = ($urandom_range(99) < 10);
				2: taken = pool_tick[k][0];
				default: taken = (pool_tick[k] % 3 != 0);
			endcase
			pool_tick[k]++;
			if ($urandom_range(99) < 15) begin
				addr = $urandom;
				taken = 1'($urandom_range(1));
			end
			send_branch(addr, taken, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		tbp_result_t w;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$error("result transfer with no branch outstanding");
				n_errors++;
			end else begin
				w = pending_outcomes.pop_front();
				n_checked++;
				if (!prediction_correct) n_mispredicts++;
				if (predicted_taken !== w.predicted_taken) begin
					$error("predicted_taken: expected %0b, got %0b",
						w.predicted_taken, predicted_taken);
					n_errors++;
				end
				if (prediction_correct !== w.prediction_correct) begin
					$error("prediction_correct: expected %0b, got %0b",
						w.prediction_correct, prediction_correct);
					n_errors++;
				end
				if (chose_bimodal !== w.chose_bimodal) begin
					$error("chose_bimodal: expected %0b, got %0b",
						w.chose_bimodal, chose_bimodal);
					n_errors++;
				end
				if (bimodal_taken !== w.bimodal_taken) begin
					$error("bimodal_taken: expected %0b, got %0b",
						w.bimodal_taken, bimodal_taken);
					n_errors++;
				end
				if (gshare_taken !== w.gshare_taken) begin
					$error("gshare_taken: expected %0b, got %0b",
						w.gshare_taken, gshare_taken);
					n_errors++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		branch_address <= '0;
		branch_taken <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		n_sent = 0;
		n_checked = 0;
		n_errors = 0;
		n_mispredicts = 0;
		idle_enable = 1'b1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			bim_ctr[i] = CTR_MIN;
			gsh_ctr[i] = CTR_MIN;
			sel_ctr[i] = CTR_MIN;
		end
		ghist = '0;
		hist_len = HIST_LEN_RESET;

		// first two rows hit freshly cleared entries
		directed_rows = '{
			'{32'h0000_0000, 1'b0, 1'b1, tbp_result_t'(5'b01000)},
			'{32'hFFFF_FFFF, 1'b1, 1'b1, tbp_result_t'(5'b00000)},
			'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
			'{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
			'{32'hFFFF_FC00, 1'b1, 1'b0, '0},
			'{32'hFFFF_FC00, 1'b1, 1'b0, '0},
			'{32'hFFFF_FC00, 1'b0, 1'b0, '0},
			'{32'h8000_0001, 1'b1, 1'b0, '0},
			'{32'h5555_5555, 1'b0, 1'b0, '0},
			'{32'hAAAA_AAAA, 1'b1, 1'b0, '0},
			'{32'h1234_5678, 1'b1, 1'b0, '0},
			'{32'h1234_5678, 1'b0, 1'b0, '0},
			'{32'h1234_5678, 1'b1, 1'b0, '0},
			'{32'h1234_5678, 1'b0, 1'b0, '0}
		};
		// zero, too large, one, just over the top, full, mid values, then a random one
		phase_len = '{4'd0, 4'd15, 4'd1, 4'd11, 4'd10, 4'd7, 4'd3, 4'd0};
		phase_len[N_PHASES-1] = HIST_LEN_W'($urandom_range(15));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_branch(directed_rows[i].addr, directed_rows[i].taken,
				directed_rows[i].has_want, directed_rows[i].want);
		end
		run_random_branches(200);

		for (int ph = 0; ph < N_PHASES - 1; ph++) begin
			write_history_length(phase_len[ph]);
			idle_enable = (ph != 2);
			run_random_branches(215);
		end
		write_history_length(phase_len[N_PHASES-1]);
		idle_enable = 1'b1;
		run_random_branches(50);

		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d branches over %0d history lengths, checked %0d results",
			n_sent, N_PHASES + 1, n_checked);
		$display("block mispredicted %0d of them", n_mispredicts);
		if (n_errors == 0) begin
			$display("[tournament_branch_predictor] OK");
		end else begin
			$display("[tournament_branch_predictor] ERROR");
		end
		$finish;
	end

endmodule
